FILE: hdl/kpsq_pkg.sv
// package: shared types and constants for the keypad scan event queue
package kpsq_pkg;

    localparam int KEY_W        = 5;
    localparam int MATRIX_KEYS  = 16;
    localparam int POS_W        = 4;
    localparam int TIME_W       = 32;
    localparam int LOCKOUT_W    = 16;
    localparam int MAP_W        = 40;
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 5;
    localparam int QUEUE_SLOTS_DEF = 16;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd50;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_LOCKOUT   = 2'd0;
    localparam logic [1:0] REG_MAP_UPPER = 2'd1;
    localparam logic [1:0] REG_MAP_LOWER = 2'd2;

    typedef enum logic [1:0] {
        REQ_POLL  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_FLUSH = 2'd2
    } kpsq_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCK,
        ST_SCAN,
        ST_MAP,
        ST_POP,
        ST_DONE
    } kpsq_state_t;

endpackage

FILE: hdl/kpsq_ifs.sv
// interfaces: request and response channels of the keypad scan event queue
interface kpsq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [15:0] first_sample;
    logic [15:0] confirm_sample;

    modport source (output valid, req_type, now_ms, first_sample, confirm_sample,
                    input ready);
    modport sink   (input valid, req_type, now_ms, first_sample, confirm_sample,
                    output ready);
endinterface

interface kpsq_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] new_key;
    logic [4:0] popped_key;
    logic       queue_nonempty;

    modport source (output valid, new_key, popped_key, queue_nonempty, input ready);
    modport sink   (input valid, new_key, popped_key, queue_nonempty, output ready);
endinterface

FILE: hdl/keypad_scan_event_queue.sv
// Keypad scan event queue: qualifies 4x4 matrix polls and queues key codes.
//
// Requests come in on req (valid/ready): a poll with time and two matrix
// samples, a pop of one queued key, or a flush. Every request gives exactly
// one response on rsp (valid/ready): new_key, popped_key, queue_nonempty.
// Registers are written over the APB port: lockout at 0x00, key table for
// positions 0..7 at 0x08 and for positions 8..15 at 0x10 (5 bits per key).
//
// One request is handled at a time. A flush or an unused request code goes
// straight to the response, a pop reads the queue first. A poll ends after
// the lockout check when locked out or idle, else it scans to p, where p
// (0..15) is the first position pressed in both samples, one position at a
// time through the bit-test shifter, and then maps p to its key code.
// req.ready rises together with response valid, when the response register is loaded.
// The response register holds while rsp.ready is low; the block takes the
// next request meanwhile and waits at the end of it until the slot frees.
// Reset clears state, slots, lockout to 50 ms and key table to zero.
module keypad_scan_event_queue
    import kpsq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    kpsq_req_if.sink               req,
    kpsq_rsp_if.source             rsp
);

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_SLOTS - 1);

    kpsq_state_t state_reg, state_next;

    logic [1:0]             req_type_reg, req_type_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [MATRIX_KEYS-1:0] both_reg, both_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [KEY_W-1:0]       fresh_reg, fresh_next;
    logic [KEY_W-1:0]       popped_reg, popped_next;
    logic [KEY_W-1:0]       prev_key_reg, prev_key_next;
    logic [TIME_W-1:0]      accept_time_reg, accept_time_next;
    logic [SLOT_W-1:0]      write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]      read_slot_reg, read_slot_next;

    logic [LOCKOUT_W-1:0]   lockout_reg, lockout_next;
    logic [MAP_W-1:0]       map_upper_reg, map_upper_next;
    logic [MAP_W-1:0]       map_lower_reg, map_lower_next;

    logic                   out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]       out_new_key_reg, out_new_key_next;
    logic [KEY_W-1:0]       out_popped_reg, out_popped_next;
    logic                   out_nonempty_reg, out_nonempty_next;

    logic [KEY_W-1:0]       event_store [QUEUE_SLOTS];
    logic [KEY_W-1:0]       rd_data_reg;
    logic                   mem_we;

    logic                   req_xfer;
    logic                   cfg_write;
    logic [TIME_W-1:0]      elapsed;
    logic                   locked;
    logic [2*MAP_W-1:0]     keymap;
    logic [KEY_W-1:0]       code;
    logic [SLOT_W-1:0]      wr_inc;
    logic [SLOT_W-1:0]      rd_inc;
    logic                   full;
    logic                   empty;
    logic                   load_out;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    assign elapsed = now_reg - accept_time_reg;
    assign locked  = elapsed < {{(TIME_W-LOCKOUT_W){1'b0}}, lockout_reg};
    assign keymap  = {map_lower_reg, map_upper_reg};
    assign code    = keymap[pos_reg*KEY_W +: KEY_W];
    assign wr_inc  = (write_slot_reg == SLOT_LAST) ? '0 : write_slot_reg + 1'b1;
    assign rd_inc  = (read_slot_reg == SLOT_LAST) ? '0 : read_slot_reg + 1'b1;
    assign full    = (wr_inc == read_slot_reg);
    assign empty   = (write_slot_reg == read_slot_reg);
    assign load_out = !out_valid_reg || rsp.ready;

    assign rsp.valid          = out_valid_reg;
    assign rsp.new_key        = out_new_key_reg;
    assign rsp.popped_key     = out_popped_reg;
    assign rsp.queue_nonempty = out_nonempty_reg;

    // register read
    always_comb
    begin
        case (paddr[4:3])
            REG_LOCKOUT:   prdata = {{(APB_DATA_W-LOCKOUT_W){1'b0}}, lockout_reg};
            REG_MAP_UPPER: prdata = {{(APB_DATA_W-MAP_W){1'b0}}, map_upper_reg};
            REG_MAP_LOWER: prdata = {{(APB_DATA_W-MAP_W){1'b0}}, map_lower_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        lockout_next   = lockout_reg;
        map_upper_next = map_upper_reg;
        map_lower_next = map_lower_reg;
        if (cfg_write)
        begin
            case (paddr[4:3])
                REG_LOCKOUT:   lockout_next   = pwdata[LOCKOUT_W-1:0];
                REG_MAP_UPPER: map_upper_next = pwdata[MAP_W-1:0];
                REG_MAP_LOWER: map_lower_next = pwdata[MAP_W-1:0];
                default:       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req.req_type)
                        REQ_POLL: state_next = ST_LOCK;
                        REQ_POP:  state_next = ST_POP;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOCK:
            begin
                if (locked || (both_reg == '0))
                    state_next = ST_DONE;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (both_reg[0])
                    state_next = ST_MAP;
            end
            ST_MAP:  state_next = ST_DONE;
            ST_POP:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and queue control
    always_comb
    begin
        req_type_next     = req_type_reg;
        now_next          = now_reg;
        both_next         = both_reg;
        pos_next          = pos_reg;
        fresh_next        = fresh_reg;
        popped_next       = popped_reg;
        prev_key_next     = prev_key_reg;
        accept_time_next  = accept_time_reg;
        write_slot_next   = write_slot_reg;
        read_slot_next    = read_slot_reg;
        out_valid_next    = out_valid_reg;
        out_new_key_next  = out_new_key_reg;
        out_popped_next   = out_popped_reg;
        out_nonempty_next = out_nonempty_reg;
        mem_we            = 1'b0;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    req_type_next = req.req_type;
                    now_next      = req.now_ms;
                    both_next     = req.first_sample & req.confirm_sample;
                    pos_next      = '0;
                    fresh_next    = '0;
                    popped_next   = '0;
                    if (req.req_type == REQ_FLUSH)
                    begin
                        write_slot_next = '0;
                        read_slot_next  = '0;
                    end
                end
            end
            ST_LOCK:
            begin
                // idle matrix outside lockout forgets the held key
                if (!locked && (both_reg == '0))
                    prev_key_next = '0;
            end
            ST_SCAN:
            begin
                if (!both_reg[0])
                begin
                    both_next = both_reg >> 1;
                    pos_next  = pos_reg + 1'b1;
                end
            end
            ST_MAP:
            begin
                if (code != prev_key_reg)
                begin
                    prev_key_next    = code;
                    accept_time_next = now_reg;
                    fresh_next       = code;
                    // zero code is reported but never queued; full queue drops
                    if ((code != '0) && !full)
                    begin
                        mem_we          = 1'b1;
                        write_slot_next = wr_inc;
                    end
                end
            end
            ST_POP:
            begin
                if (!empty)
                begin
                    popped_next    = rd_data_reg;
                    read_slot_next = rd_inc;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next    = 1'b1;
                    out_new_key_next  = fresh_reg;
                    out_popped_next   = popped_reg;
                    out_nonempty_next = !empty;
                end
            end
            default: ;
        endcase
    end

    // event store, registered read at the read slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
            event_store[write_slot_reg] <= code;
        rd_data_reg <= event_store[read_slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prev_key_reg     <= '0;
            accept_time_reg  <= '0;
            write_slot_reg   <= '0;
            read_slot_reg    <= '0;
            lockout_reg      <= LOCKOUT_RESET;
            map_upper_reg    <= '0;
            map_lower_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_key_reg     <= prev_key_next;
            accept_time_reg  <= accept_time_next;
            write_slot_reg   <= write_slot_next;
            read_slot_reg    <= read_slot_next;
            lockout_reg      <= lockout_next;
            map_upper_reg    <= map_upper_next;
            map_lower_reg    <= map_lower_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg     <= req_type_next;
        now_reg          <= now_next;
        both_reg         <= both_next;
        pos_reg          <= pos_next;
        fresh_reg        <= fresh_next;
        popped_reg       <= popped_next;
        out_new_key_reg  <= out_new_key_next;
        out_popped_reg   <= out_popped_next;
        out_nonempty_reg <= out_nonempty_next;
    end

`ifndef SYNTH
    a_scan_has_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (both_reg != '0))
        else $error("scan running on an empty sample");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (wr_inc != read_slot_reg))
        else $error("push into a full queue");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && (req.req_type == REQ_FLUSH))
            |=> ((write_slot_reg == '0) && (read_slot_reg == '0)))
        else $error("flush did not clear slots");

    a_pop_only_key: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (req_type_reg != REQ_POP)) |-> (popped_reg == '0))
        else $error("popped key outside a pop");

    a_poll_only_key: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (req_type_reg != REQ_POLL)) |-> (fresh_reg == '0))
        else $error("new key outside a poll");
`endif

endmodule

FILE: tb/sv/tb_keypad_scan_event_queue.sv
// testbench for the keypad scan event queue: directed table, then random request streams
module tb_keypad_scan_event_queue;
    import kpsq_pkg::*;

    localparam int          SLOTS       = QUEUE_SLOTS_DEF;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          RESET_ROWS  = 5;
    localparam int          DIR_COUNT   = 27;
    localparam int          PHASES      = 6;
    localparam int          PHASE_ITEMS = 100;
    localparam logic [1:0]  REQ_SPARE   = 2'd3;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [TIME_W-1:0]      now_ms;
        logic [MATRIX_KEYS-1:0] first_sample;
        logic [MATRIX_KEYS-1:0] confirm_sample;
    } key_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] new_key;
        logic [KEY_W-1:0] popped_key;
        logic             queue_nonempty;
    } key_rsp_t;

    typedef struct packed {
        logic     pinned;
        key_req_t req;
        key_rsp_t rsp;
    } stim_row_t;

    // rows before RESET_ROWS run on reset settings and carry their response;
    // the rest run with lockout 0 and a known key table
    localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
        {1'b1, REQ_POP,   32'd0,          16'h0000, 16'h0000, 5'd0, 5'd0, 1'b0},
        {1'b1, REQ_FLUSH, 32'd0,          16'hFFFF, 16'hFFFF, 5'd0, 5'd0, 1'b0},
        {1'b1, REQ_SPARE, 32'hFFFF_FFFF,  16'hFFFF, 16'hFFFF, 5'd0, 5'd0, 1'b0},
        {1'b1, REQ_POLL,  32'd49,         16'hFFFF, 16'hFFFF, 5'd0, 5'd0, 1'b0},
        {1'b1, REQ_POLL,  32'd50,         16'hFFFF, 16'hFFFF, 5'd0, 5'd0, 1'b0},
        {1'b0, REQ_POLL,  32'd1000,       16'h0001, 16'h0001, 11'd0},
        {1'b0, REQ_POLL,  32'd1001,       16'h0001, 16'h0001, 11'd0},
        {1'b0, REQ_POLL,  32'd1002,       16'h8000, 16'h8000, 11'd0},
        {1'b0, REQ_POLL,  32'd1003,       16'h0001, 16'h0003, 11'd0},
        {1'b0, REQ_POLL,  32'd1004,       16'hC000, 16'h4000, 11'd0},
        {1'b0, REQ_POLL,  32'd1005,       16'h00F0, 16'h0F00, 11'd0},
        {1'b0, REQ_POLL,  32'd1006,       16'h0002, 16'h0002, 11'd0},
        {1'b0, REQ_POLL,  32'd1007,       16'h0004, 16'h0004, 11'd0},
        {1'b0, REQ_POLL,  32'd1008,       16'h0002, 16'h0002, 11'd0},
        {1'b0, REQ_POLL,  32'd1009,       16'h0004, 16'h0004, 11'd0},
        {1'b0, REQ_POLL,  32'd1010,       16'h0002, 16'h0002, 11'd0},
        {1'b0, REQ_POLL,  32'd1011,       16'h0004, 16'h0004, 11'd0},
        {1'b0, REQ_POLL,  32'd1012,       16'h0002, 16'h0002, 11'd0},
        {1'b0, REQ_POLL,  32'd1013,       16'h0004, 16'h0004, 11'd0},
        {1'b0, REQ_POLL,  32'd1014,       16'h0002, 16'h0002, 11'd0},
        {1'b0, REQ_POLL,  32'd1015,       16'h0004, 16'h0004, 11'd0},
        {1'b0, REQ_POLL,  32'd1016,       16'h0002, 16'h0002, 11'd0},
        {1'b0, REQ_POLL,  32'd1017,       16'h0004, 16'h0004, 11'd0},
        {1'b0, REQ_POLL,  32'd1018,       16'h0002, 16'h0002, 11'd0},
        {1'b0, REQ_POP,   32'd1019,       16'hFFFF, 16'h0000, 11'd0},
        {1'b0, REQ_FLUSH, 32'd1020,       16'h0000, 16'hFFFF, 11'd0},
        {1'b0, REQ_POP,   32'd1021,       16'h5555, 16'hAAAA, 11'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  sink_ready = 1'b1;

    kpsq_req_if req_ch ();
    kpsq_rsp_if rsp_ch ();

    keypad_scan_event_queue u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    assign rsp_ch.ready = sink_ready;

    // model of the block's state and registers
    logic [LOCKOUT_W-1:0] m_lockout;
    logic [MAP_W-1:0]     m_map_upper;
    logic [MAP_W-1:0]     m_map_lower;
    logic [KEY_W-1:0]     m_prev_key;
    logic [TIME_W-1:0]    m_accept_time;
    logic [KEY_W-1:0]     m_ring [SLOTS];
    int                   m_wr;
    int                   m_rd;

    key_rsp_t             rsp_due [$];
    key_rsp_t             due_now;
    int                   fails = 0;
    int unsigned          cycles = 0;
    int                   burst_left = 0;
    int                   stall_tick = 0;
    int                   stall_mode = 0;
    logic [TIME_W-1:0]    ms_now = '0;
    logic [MATRIX_KEYS-1:0] held_keys = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: ready pattern changes mode at random, paced by stall_tick
    always @(posedge clk)
    begin
        if (stall_tick % 128 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       sink_ready <= 1'b1;
            1:       sink_ready <= ($urandom_range(0, 3) != 0);
            2:       sink_ready <= ($urandom_range(0, 3) == 0);
            default: sink_ready <= (stall_tick % 13) >= 5;
        endcase
        stall_tick++;
    end

    function automatic key_rsp_t compute_rsp(input key_req_t r);
        key_rsp_t               o;
        logic [MATRIX_KEYS-1:0] both;
        logic [MAP_W-1:0]       word;
        logic [KEY_W-1:0]       code;
        logic [TIME_W-1:0]      since;
        int                     pos;
        o = '0;
        case (r.req_type)
            REQ_POLL:
            begin
                since = r.now_ms - m_accept_time;
                both  = r.first_sample & r.confirm_sample;
                // inside the lockout window a poll leaves everything alone
                if (since >= TIME_W'(m_lockout))
                begin
                    if (both == '0)
                        m_prev_key = '0;
                    else
                    begin
                        pos = 0;
                        while (!both[pos])
                            pos++;
                        word = (pos < 8) ? m_map_upper : m_map_lower;
                        code = word[(pos % 8) * KEY_W +: KEY_W];
                        if (code != m_prev_key)
                        begin
                            m_prev_key    = code;
                            m_accept_time = r.now_ms;
                            o.new_key     = code;
                            // zero codes are never queued, a full ring drops the key
                            if (code != '0 && (m_wr + 1) % SLOTS != m_rd)
                            begin
                                m_ring[m_wr] = code;
                                m_wr = (m_wr + 1) % SLOTS;
                            end
                        end
                    end
                end
            end
            REQ_POP:
            begin
                if (m_wr != m_rd)
                begin
                    o.popped_key = m_ring[m_rd];
                    m_rd = (m_rd + 1) % SLOTS;
                end
            end
            REQ_FLUSH:
            begin
                m_wr = 0;
                m_rd = 0;
            end
            default: ;
        endcase
        o.queue_nonempty = (m_wr != m_rd);
        return o;
    endfunction

    task automatic check_field(input string what, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (rsp_due.size() == 0)
            begin
                $display("%0t: response with none due, expected none, actual %0d/%0d/%0d",
                         $time, rsp_ch.new_key, rsp_ch.popped_key, rsp_ch.queue_nonempty);
                fails++;
            end
            else
            begin
                due_now = rsp_due.pop_front();
                check_field("new_key", due_now.new_key, rsp_ch.new_key);
                check_field("popped_key", due_now.popped_key, rsp_ch.popped_key);
                check_field("queue_nonempty", KEY_W'(due_now.queue_nonempty),
                            KEY_W'(rsp_ch.queue_nonempty));
            end
        end
    end

    // write one register, then read it back in a second transfer
    task automatic program_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] kept;
        kept = value & ((idx == REG_LOCKOUT) ? 64'hFFFF : 64'hFF_FFFF_FFFF);
        case (idx)
            REG_LOCKOUT:   m_lockout   = kept[LOCKOUT_W-1:0];
            REG_MAP_UPPER: m_map_upper = kept[MAP_W-1:0];
            default:       m_map_lower = kept[MAP_W-1:0];
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== kept)
        begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, kept, prdata);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // sender: bursts of back-to-back transfers separated by random gaps
    task automatic send_req(input key_req_t r, input logic pinned, input key_rsp_t pinned_rsp);
        int       gap;
        key_rsp_t calc;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= r.req_type;
        req_ch.now_ms         <= r.now_ms;
        req_ch.first_sample   <= r.first_sample;
        req_ch.confirm_sample <= r.confirm_sample;
        do @(posedge clk); while (!req_ch.ready);
        burst_left--;
        calc = compute_rsp(r);
        rsp_due.push_back(pinned ? pinned_rsp : calc);
    endtask

    // hold the sender off until every response has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (rsp_due.size() != 0);
        @(posedge clk);
        burst_left = 0;
    endtask

    task automatic random_phase(input int count);
        key_req_t r;
        int       pick;
        int       n;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 24) == 0)
                ms_now += $urandom();
            else
                ms_now += $urandom_range(0, int'(m_lockout) + int'(m_lockout) / 2 + 4);
            // the pressed pattern changes now and then: release, one key, or several
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: held_keys = '0;
                    8:       held_keys = MATRIX_KEYS'($urandom_range(0, 16'hFFFF));
                    9:       held_keys = (16'd1 << $urandom_range(0, 15)) |
                                         (16'd1 << $urandom_range(0, 15));
                    default: held_keys = 16'd1 << $urandom_range(0, 15);
                endcase
            end
            r.now_ms         = ms_now;
            r.first_sample   = held_keys;
            r.confirm_sample = held_keys;
            // contact bounce between the two reads
            if ($urandom_range(0, 4) == 0)
                r.confirm_sample ^= MATRIX_KEYS'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 9) == 0)
                r.first_sample ^= MATRIX_KEYS'($urandom_range(0, 16'hFFFF));
            if (pick < 60)
                r.req_type = REQ_POLL;
            else if (pick < 82)
                r.req_type = REQ_POP;
            else if (pick < 85)
                r.req_type = REQ_FLUSH;
            else if (pick < 87)
                r.req_type = REQ_SPARE;
            else
            begin
                r.req_type       = REQ_POLL;
                r.now_ms         = $urandom();
                r.first_sample   = MATRIX_KEYS'($urandom_range(0, 16'hFFFF));
                r.confirm_sample = MATRIX_KEYS'($urandom_range(0, 16'hFFFF));
            end
            if (r.req_type != REQ_SPARE)
                n++;
            send_req(r, 1'b0, '0);
        end
    endtask

    initial
    begin
        logic [APB_DATA_W-1:0] lk;
        logic [APB_DATA_W-1:0] up;
        logic [APB_DATA_W-1:0] lo;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_POLL;
        req_ch.now_ms         = '0;
        req_ch.first_sample   = '0;
        req_ch.confirm_sample = '0;
        m_lockout     = LOCKOUT_RESET;
        m_map_upper   = '0;
        m_map_lower   = '0;
        m_prev_key    = '0;
        m_accept_time = '0;
        m_wr          = 0;
        m_rd          = 0;
        foreach (m_ring[i])
            m_ring[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            if (i == RESET_ROWS)
            begin
                // positions 0..7 map to codes 1..8, 8..13 to 9..14, 14 to 31, 15 to zero
                up = '0;
                lo = '0;
                for (int p = 0; p < 8; p++)
                begin
                    up[p * KEY_W +: KEY_W] = KEY_W'(p + 1);
                    lo[p * KEY_W +: KEY_W] = KEY_W'((p < 6) ? p + 9 : ((p == 6) ? 31 : 0));
                end
                settle();
                program_reg(REG_LOCKOUT, 64'd0);
                program_reg(REG_MAP_UPPER, up);
                program_reg(REG_MAP_LOWER, lo);
            end
            send_req(DIR_ROWS[i].req, DIR_ROWS[i].pinned, DIR_ROWS[i].rsp);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            lk = 64'($urandom_range(0, 8));
            up = {$urandom(), $urandom()};
            lo = {$urandom(), $urandom()};
            case (ph)
                0: lk = 64'd0;
                1:
                begin
                    lk = 64'hFFFF;
                    up = '1;
                    lo = '1;
                end
                2:
                begin
                    lk = 64'($urandom_range(1, 30));
                    up = '0;
                end
                3:
                begin
                    lk = 64'(LOCKOUT_RESET);
                    lo = '0;
                end
                4: lk = {$urandom(), $urandom()};
                default: ;
            endcase
            settle();
            program_reg(REG_LOCKOUT, lk);
            program_reg(REG_MAP_UPPER, up);
            program_reg(REG_MAP_LOWER, lo);
            random_phase(PHASE_ITEMS);
        end

        settle();
        repeat (32) @(posedge clk);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
